// ===== src/mahd_pkg.sv =====
// Package for the MPEG audio header decoder: field codes, rate tables,
// divider constants and the per-stage header record. No dependencies.
package mahd_pkg;

  localparam logic [1:0] VER_MPEG25 = 2'd0;
  localparam logic [1:0] VER_RSVD   = 2'd1;
  localparam logic [1:0] VER_MPEG2  = 2'd2;
  localparam logic [1:0] VER_MPEG1  = 2'd3;

  localparam logic [1:0] LAY_RSVD = 2'd0;
  localparam logic [1:0] LAY_III  = 2'd1;
  localparam logic [1:0] LAY_II   = 2'd2;
  localparam logic [1:0] LAY_I    = 2'd3;

  localparam logic [1:0] SRI_11K  = 2'd0;
  localparam logic [1:0] SRI_12K  = 2'd1;
  localparam logic [1:0] SRI_8K   = 2'd2;
  localparam logic [1:0] SRI_RSVD = 2'd3;

  localparam logic [3:0] BRI_FREE = 4'd0;
  localparam logic [3:0] BRI_BAD  = 4'd15;

  localparam logic [1:0] MODE_MONO = 2'd3;
  localparam logic [1:0] EMPH_RSVD = 2'd2;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] SYNC_MASK = 8'hE0;

  localparam logic [5:0] SIDE_LONG  = 6'd36;
  localparam logic [5:0] SIDE_MID   = 6'd21;
  localparam logic [5:0] SIDE_SHORT = 6'd13;

  localparam logic [2:0] PAD_SLOT_I  = 3'd4;
  localparam logic [2:0] PAD_SLOT_23 = 3'd1;

  // frame length = 192000 * c * (kbps/8) / hz, hz = base * 2^shift
  localparam int unsigned NUM_W  = 22;
  localparam int unsigned Q_W    = 14;
  localparam int unsigned RCP_SH = 22;
  localparam logic [13:0] RCP_11K = 14'd9510;   // floor(2^22 / 441)
  localparam logic [8:0]  DIV_11K = 9'd441;     // 11025 / 25 per 192000/7680
  localparam logic [12:0] MUL_11K = 13'd7680;
  localparam logic [4:0]  MUL_12K = 5'd16;
  localparam logic [4:0]  MUL_8K  = 5'd24;

  localparam logic [8:0] KBPS_V1L1 [16] = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160,
    9'd192, 9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [8:0] KBPS_V1L2 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
    9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [8:0] KBPS_V1L3 [16] = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64,
    9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [8:0] KBPS_V2L1 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
    9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [8:0] KBPS_V2L23 [16] = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40,
    9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

  typedef struct packed {
    logic        ok;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic        crc;
    logic [8:0]  kbps;
    logic [15:0] hz;
    logic [1:0]  mode;
    logic [1:0]  mext;
    logic [2:0]  flags;
    logic [1:0]  emph;
    logic [5:0]  side;
  } hdr_t;

  function automatic logic [8:0] kbps_lookup(input logic [1:0] ver, input logic [1:0] lay,
                                             input logic [3:0] bri);
    logic [8:0] r;
    r = '0;
    if (ver == VER_MPEG1) begin
      unique case (lay)
        LAY_I:   r = KBPS_V1L1[bri];
        LAY_II:  r = KBPS_V1L2[bri];
        LAY_III: r = KBPS_V1L3[bri];
        default: r = '0;
      endcase
    end else begin
      unique case (lay)
        LAY_I:          r = KBPS_V2L1[bri];
        LAY_II, LAY_III: r = KBPS_V2L23[bri];
        default:        r = '0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [15:0] hz_lookup(input logic [1:0] ver, input logic [1:0] sri);
    logic [15:0] r;
    r = '0;
    unique case (sri)
      SRI_11K: r = (ver == VER_MPEG1) ? 16'd44100 : (ver == VER_MPEG2) ? 16'd22050 : 16'd11025;
      SRI_12K: r = (ver == VER_MPEG1) ? 16'd48000 : (ver == VER_MPEG2) ? 16'd24000 : 16'd12000;
      SRI_8K:  r = (ver == VER_MPEG1) ? 16'd32000 : (ver == VER_MPEG2) ? 16'd16000 : 16'd8000;
      default: r = '0;
    endcase
    return r;
  endfunction

  // frame coefficient divided by 24
  function automatic logic [2:0] coef_unit(input logic [1:0] ver, input logic [1:0] lay);
    logic [2:0] r;
    if (ver == VER_MPEG1) begin
      r = (lay == LAY_I) ? 3'd2 : 3'd6;
    end else begin
      unique case (lay)
        LAY_I:   r = 3'd1;
        LAY_II:  r = 3'd6;
        default: r = 3'd3;
      endcase
    end
    return r;
  endfunction

endpackage

// ===== src/mpeg_audio_header_decode_core.sv =====
// Top level of the MPEG audio frame header decoder: four-stage pipeline.
// Depends on mahd_pkg.
//
//  channel | dir | width | beat carries
//  in_     | in  | 32    | header_word
//  out_    | out | 64    | decoded header fields and frame length
//
// One header per cycle while out_tready keeps the output moving. The depth is set by the
// 11025 Hz family reciprocal multiply and its remainder correction stage.
// Reset (rst_n low, synchronous) empties all stages. A stall on out_tready holds every
// full stage, empty ones still fill; in_tready drops only when the whole pipeline is full.
module mpeg_audio_header_decode_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] header_word
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] header_ok, [2:1] version_code, [4:3] layer_code, [5] crc_present,
  // [14:6] bitrate_kbps, [30:15] sample_rate_hz, [32:31] channel_mode,
  // [34:33] mode_extension, [37:35] flag_bits, [39:38] emphasis_code,
  // [51:40] frame_bytes, [57:52] side_info_offset, [63:58] zero
  output logic [63:0] out_tdata
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4_r || out_tready;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_tready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_tvalid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  // stage 1: check, slice, table lookups
  mahd_pkg::hdr_t s1_nxt;
  logic [1:0]     s1_ver, s1_lay, s1_sri;
  logic [3:0]     s1_bri;
  logic           s1_ok;
  logic [8:0]     s1_kbps;
  logic [2:0]     c_nxt, pad_nxt;
  logic [1:0]     sh_nxt;

  assign s1_ver = in_tdata[20:19];
  assign s1_lay = in_tdata[18:17];
  assign s1_bri = in_tdata[15:12];
  assign s1_sri = in_tdata[11:10];
  assign s1_ok  = (in_tdata[31:24] == mahd_pkg::SYNC_BYTE)
               && ((in_tdata[23:16] & mahd_pkg::SYNC_MASK) == mahd_pkg::SYNC_MASK)
               && (s1_ver != mahd_pkg::VER_RSVD) && (s1_lay != mahd_pkg::LAY_RSVD)
               && (s1_bri != mahd_pkg::BRI_BAD) && (s1_bri != mahd_pkg::BRI_FREE)
               && (s1_sri != mahd_pkg::SRI_RSVD) && (in_tdata[1:0] != mahd_pkg::EMPH_RSVD);
  assign s1_kbps = mahd_pkg::kbps_lookup(s1_ver, s1_lay, s1_bri);

  always_comb begin
    s1_nxt.ok    = s1_ok;
    s1_nxt.ver   = s1_ver;
    s1_nxt.lay   = s1_lay;
    s1_nxt.crc   = ~in_tdata[16];
    s1_nxt.kbps  = s1_ok ? s1_kbps : '0;
    s1_nxt.hz    = s1_ok ? mahd_pkg::hz_lookup(s1_ver, s1_sri) : '0;
    s1_nxt.mode  = in_tdata[7:6];
    s1_nxt.mext  = in_tdata[5:4];
    s1_nxt.flags = {in_tdata[8], in_tdata[3], in_tdata[2]};
    s1_nxt.emph  = in_tdata[1:0];
    if (!s1_ok) begin
      s1_nxt.side = '0;
    end else if (s1_ver == mahd_pkg::VER_MPEG1) begin
      s1_nxt.side = (in_tdata[7:6] != mahd_pkg::MODE_MONO) ? mahd_pkg::SIDE_LONG
                                                            : mahd_pkg::SIDE_MID;
    end else begin
      s1_nxt.side = (in_tdata[7:6] != mahd_pkg::MODE_MONO) ? mahd_pkg::SIDE_MID
                                                            : mahd_pkg::SIDE_SHORT;
    end
    c_nxt = s1_ok ? mahd_pkg::coef_unit(s1_ver, s1_lay) : '0;
    if (s1_ok && in_tdata[9]) begin
      pad_nxt = (s1_lay == mahd_pkg::LAY_I) ? mahd_pkg::PAD_SLOT_I : mahd_pkg::PAD_SLOT_23;
    end else begin
      pad_nxt = '0;
    end
    unique case (s1_ver)
      mahd_pkg::VER_MPEG1: sh_nxt = 2'd2;
      mahd_pkg::VER_MPEG2: sh_nxt = 2'd1;
      default:             sh_nxt = 2'd0;
    endcase
  end

  mahd_pkg::hdr_t s1_r, s2_r, s3_r;
  logic [2:0] s1_c_r, s1_pad_r, s2_pad_r, s3_pad_r;
  logic [5:0] s1_k_r;
  logic [1:0] s1_sri_r, s1_sh_r, s2_sh_r, s3_sh_r;
  logic       s2_div_r, s3_div_r;
  logic [mahd_pkg::NUM_W-1:0] s2_num_r, s3_num_r;
  logic [mahd_pkg::Q_W-1:0]   s3_q_r;
  logic [63:0] out_r;

  // stage 2: scaled numerator for the selected sample rate family
  logic [8:0]                  p2;
  logic [mahd_pkg::NUM_W-1:0]  num_nxt;
  assign p2 = 9'(s1_c_r) * 9'(s1_k_r);
  always_comb begin
    case (s1_sri_r)
      mahd_pkg::SRI_11K: num_nxt = mahd_pkg::NUM_W'(p2) * mahd_pkg::NUM_W'(mahd_pkg::MUL_11K);
      mahd_pkg::SRI_12K: num_nxt = mahd_pkg::NUM_W'(p2) * mahd_pkg::NUM_W'(mahd_pkg::MUL_12K);
      default:           num_nxt = mahd_pkg::NUM_W'(p2) * mahd_pkg::NUM_W'(mahd_pkg::MUL_8K);
    endcase
  end

  // stage 3: reciprocal estimate of num / 441 for the 11025 Hz family, else num passed through
  logic [mahd_pkg::NUM_W+13:0] prod3;
  logic [mahd_pkg::Q_W-1:0]    q_nxt;
  assign prod3 = (mahd_pkg::NUM_W+14)'(s2_num_r) * (mahd_pkg::NUM_W+14)'(mahd_pkg::RCP_11K);
  assign q_nxt = s2_div_r ? prod3[mahd_pkg::RCP_SH +: mahd_pkg::Q_W]
                          : s2_num_r[mahd_pkg::Q_W-1:0];

  // stage 4: correct estimate, scale by rate multiple, add padding
  logic [mahd_pkg::NUM_W:0]  qm4, rem4;
  logic [mahd_pkg::Q_W-1:0]  qc4, qs4;
  logic [11:0]               len4;
  logic [63:0]               out_nxt;
  assign qm4  = (mahd_pkg::NUM_W+1)'(s3_q_r) * (mahd_pkg::NUM_W+1)'(mahd_pkg::DIV_11K);
  assign rem4 = (mahd_pkg::NUM_W+1)'(s3_num_r) - qm4;
  assign qc4  = s3_q_r + mahd_pkg::Q_W'(s3_div_r
                && (rem4 >= (mahd_pkg::NUM_W+1)'(mahd_pkg::DIV_11K)));
  assign qs4  = qc4 >> s3_sh_r;
  assign len4 = qs4[11:0] + 12'(s3_pad_r);
  assign out_nxt = {6'd0, s3_r.side, len4, s3_r.emph, s3_r.flags, s3_r.mext, s3_r.mode,
                    s3_r.hz, s3_r.kbps, s3_r.crc, s3_r.lay, s3_r.ver, s3_r.ok};

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_r     <= s1_nxt;
      s1_c_r   <= c_nxt;
      s1_k_r   <= s1_kbps[8:3];
      s1_sri_r <= s1_sri;
      s1_pad_r <= pad_nxt;
      s1_sh_r  <= sh_nxt;
    end
    if (adv2) begin
      s2_r     <= s1_r;
      s2_num_r <= num_nxt;
      s2_div_r <= (s1_sri_r == mahd_pkg::SRI_11K);
      s2_pad_r <= s1_pad_r;
      s2_sh_r  <= s1_sh_r;
    end
    if (adv3) begin
      s3_r     <= s2_r;
      s3_q_r   <= q_nxt;
      s3_num_r <= s2_num_r;
      s3_div_r <= s2_div_r;
      s3_pad_r <= s2_pad_r;
      s3_sh_r  <= s2_sh_r;
    end
    if (adv4) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = out_r;

endmodule

// ===== src/mahd_checker.sv =====
// Port-level checker for mpeg_audio_header_decode_core, bound to the top level.
// Depends only on the top level's ports.
module mahd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output beat valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output beat changed");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |->
      out_tdata[14:6] == 9'd0 && out_tdata[30:15] == 16'd0
      && out_tdata[51:40] == 12'd0 && out_tdata[57:52] == 6'd0)
    else $error("invalid header with nonzero derived fields");

  a_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |->
      out_tdata[57:52] == 6'd13 || out_tdata[57:52] == 6'd21 || out_tdata[57:52] == 6'd36)
    else $error("side info offset out of set");

  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[51:40] != 12'd0)
    else $error("valid header with zero frame length");

endmodule

bind mpeg_audio_header_decode_core mahd_checker u_mahd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== sim/tb_mpeg_audio_header_decode_core.sv =====
// Testbench for mpeg_audio_header_decode_core: directed header table, then a sweep and
// random mix of headers, all checked beat by beat against typed rows or a decoder model
// in this file. Depends on mahd_pkg and the RTL under src/.
module tb_mpeg_audio_header_decode_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0]  zero;
    logic [5:0]  side;
    logic [11:0] frame;
    logic [1:0]  emph;
    logic [2:0]  flags;
    logic [1:0]  mext;
    logic [1:0]  mode;
    logic [15:0] hz;
    logic [8:0]  kbps;
    logic        crc;
    logic [1:0]  lay;
    logic [1:0]  ver;
    logic        ok;
  } hdr_result_t;

  typedef struct {
    logic [31:0] word;
    bit          typed;
    hdr_result_t want;
  } hdr_row_t;

  localparam int unsigned RATE_V1_L1 [16] = '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288,
    320, 352, 384, 416, 448, 0};
  localparam int unsigned RATE_V1_L2 [16] = '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192,
    224, 256, 320, 384, 0};
  localparam int unsigned RATE_V1_L3 [16] = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160,
    192, 224, 256, 320, 0};
  localparam int unsigned RATE_V2_L1 [16] = '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160,
    176, 192, 224, 256, 0};
  localparam int unsigned RATE_V2_L23 [16] = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112,
    128, 144, 160, 0};
  localparam int unsigned BASE_HZ [3] = '{44100, 48000, 32000};
  localparam int unsigned LONG_HOLD = 100;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;

  hdr_result_t pending_hdrs[$];
  hdr_result_t want_hdr;
  hdr_result_t got_hdr;
  hdr_row_t    hdr_rows[$];
  int unsigned mismatches = 0;
  int unsigned hdrs_sent = 0;
  int unsigned burst_left = 4;
  bit          held_off = 1'b0;

  mpeg_audio_header_decode_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic hdr_result_t decode_header(input logic [31:0] w);
    hdr_result_t r;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic [1:0]  sri;
    logic [3:0]  bri;
    int unsigned kbps;
    int unsigned hz;
    int unsigned coef;
    int unsigned len;
    logic        ok;
    r = '0;
    ver = w[20:19];
    lay = w[18:17];
    bri = w[15:12];
    sri = w[11:10];
    r.ver = ver;
    r.lay = lay;
    r.crc = ~w[16];
    r.mode = w[7:6];
    r.mext = w[5:4];
    r.flags = {w[8], w[3], w[2]};
    r.emph = w[1:0];
    ok = (w[31:24] == mahd_pkg::SYNC_BYTE) &&
         ((w[23:16] & mahd_pkg::SYNC_MASK) == mahd_pkg::SYNC_MASK) &&
         (ver != mahd_pkg::VER_RSVD) && (lay != mahd_pkg::LAY_RSVD) &&
         (bri != mahd_pkg::BRI_FREE) && (bri != mahd_pkg::BRI_BAD) &&
         (sri != mahd_pkg::SRI_RSVD) && (w[1:0] != mahd_pkg::EMPH_RSVD);
    r.ok = ok;
    if (ok) begin
      if (ver == mahd_pkg::VER_MPEG1) begin
        case (lay)
          mahd_pkg::LAY_I:  kbps = RATE_V1_L1[bri];
          mahd_pkg::LAY_II: kbps = RATE_V1_L2[bri];
          default:          kbps = RATE_V1_L3[bri];
        endcase
        coef = (lay == mahd_pkg::LAY_I) ? 48 : 144;
        hz = BASE_HZ[sri];
      end else begin
        kbps = (lay == mahd_pkg::LAY_I) ? RATE_V2_L1[bri] : RATE_V2_L23[bri];
        case (lay)
          mahd_pkg::LAY_I:  coef = 24;
          mahd_pkg::LAY_II: coef = 144;
          default:          coef = 72;
        endcase
        hz = BASE_HZ[sri] >> ((ver == mahd_pkg::VER_MPEG2) ? 1 : 2);
      end
      len = coef * kbps * 1000 / hz;
      if (w[9]) len += (lay == mahd_pkg::LAY_I) ? 4 : 1;
      r.kbps = 9'(kbps);
      r.hz = 16'(hz);
      r.frame = 12'(len);
      if (ver == mahd_pkg::VER_MPEG1)
        r.side = (r.mode != mahd_pkg::MODE_MONO) ? mahd_pkg::SIDE_LONG : mahd_pkg::SIDE_MID;
      else
        r.side = (r.mode != mahd_pkg::MODE_MONO) ? mahd_pkg::SIDE_MID : mahd_pkg::SIDE_SHORT;
    end
    return r;
  endfunction

  function automatic hdr_result_t mk_hdr(input logic ok, input logic [1:0] ver,
      input logic [1:0] lay, input logic crc, input logic [8:0] kbps, input logic [15:0] hz,
      input logic [1:0] mode, input logic [1:0] mext, input logic [2:0] flags,
      input logic [1:0] emph, input logic [11:0] frame, input logic [5:0] side);
    hdr_result_t r;
    r = '{zero: '0, side: side, frame: frame, emph: emph, flags: flags, mext: mext,
          mode: mode, hz: hz, kbps: kbps, crc: crc, lay: lay, ver: ver, ok: ok};
    return r;
  endfunction

  // well-formed header with random protection, private, mode and flag bits
  function automatic logic [31:0] form_header(input logic [1:0] ver, input logic [1:0] lay,
      input logic [3:0] bri, input logic [1:0] sri, input logic pad);
    logic [31:0] w;
    w = $urandom;
    w[31:21] = '1;
    w[20:19] = ver;
    w[18:17] = lay;
    w[15:12] = bri;
    w[11:10] = sri;
    w[9] = pad;
    if (w[1:0] == mahd_pkg::EMPH_RSVD) w[1:0] = ($urandom_range(0, 1) != 0) ? 2'd0 : 2'd3;
    return w;
  endfunction

  task automatic send_hdr(input logic [31:0] w, input hdr_result_t want);
    int unsigned gap;
    in_tdata <= w;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_hdrs.push_back(want);
    hdrs_sent++;
    burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_hdrs.size() == 0) begin
        $error("result beat 0x%016h with no header pending", out_tdata);
        mismatches++;
      end else begin
        want_hdr = pending_hdrs.pop_front();
        got_hdr = hdr_result_t'(out_tdata);
        check_field("header_ok", want_hdr.ok, got_hdr.ok);
        check_field("version_code", want_hdr.ver, got_hdr.ver);
        check_field("layer_code", want_hdr.lay, got_hdr.lay);
        check_field("crc_present", want_hdr.crc, got_hdr.crc);
        check_field("bitrate_kbps", want_hdr.kbps, got_hdr.kbps);
        check_field("sample_rate_hz", want_hdr.hz, got_hdr.hz);
        check_field("channel_mode", want_hdr.mode, got_hdr.mode);
        check_field("mode_extension", want_hdr.mext, got_hdr.mext);
        check_field("flag_bits", want_hdr.flags, got_hdr.flags);
        check_field("emphasis_code", want_hdr.emph, got_hdr.emph);
        check_field("frame_bytes", want_hdr.frame, got_hdr.frame);
        check_field("side_info_offset", want_hdr.side, got_hdr.side);
        check_field("tdata padding", want_hdr.zero, got_hdr.zero);
      end
    end
  end

  // receiver: one long hold-off to back up the pipeline, otherwise random runs and stalls
  initial begin
    int unsigned run;
    int unsigned stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && hdrs_sent >= 40) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if ($urandom_range(0, 7) == 0) begin
        run = $urandom_range(6, 20);
        repeat (run) begin
          out_tready <= ~out_tready;
          @(posedge clk);
        end
      end else begin
        run = $urandom_range(1, 24);
        out_tready <= 1'b1;
        repeat (run) @(posedge clk);
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [31:0] w;
    int unsigned pick;
    hdr_rows.push_back('{32'h0000_0000, 1'b1, mk_hdr(1'b0, mahd_pkg::VER_MPEG25,
                         mahd_pkg::LAY_RSVD, 1'b1, 9'd0, 16'd0, 2'd0, 2'd0, 3'd0, 2'd0,
                         12'd0, 6'd0)});
    hdr_rows.push_back('{32'hFFFF_FFFF, 1'b1, mk_hdr(1'b0, mahd_pkg::VER_MPEG1,
                         mahd_pkg::LAY_I, 1'b0, 9'd0, 16'd0, mahd_pkg::MODE_MONO, 2'd3,
                         3'd7, 2'd3, 12'd0, 6'd0)});
    // longest frame: MPEG2.5 Layer II 160 kbit/s at 8 kHz, padded
    hdr_rows.push_back('{32'hFFE5_EA00, 1'b1, mk_hdr(1'b1, mahd_pkg::VER_MPEG25,
                         mahd_pkg::LAY_II, 1'b0, 9'd160, 16'd8000, 2'd0, 2'd0, 3'd0, 2'd0,
                         12'd2881, mahd_pkg::SIDE_MID)});
    hdr_rows.push_back('{32'hFFFE_EBCD, 1'b1, mk_hdr(1'b1, mahd_pkg::VER_MPEG1,
                         mahd_pkg::LAY_I, 1'b1, 9'd448, 16'd32000, mahd_pkg::MODE_MONO, 2'd0,
                         3'd7, 2'd1, 12'd676, mahd_pkg::SIDE_MID)});
    hdr_rows.push_back('{32'hFFFB_9002, 1'b1, mk_hdr(1'b0, mahd_pkg::VER_MPEG1,
                         mahd_pkg::LAY_III, 1'b0, 9'd0, 16'd0, 2'd0, 2'd0, 3'd0,
                         mahd_pkg::EMPH_RSVD, 12'd0, 6'd0)});
    hdr_rows.push_back('{32'hFFFB_9000, 1'b0, '0});
    hdr_rows.push_back('{32'hFFFB_9200, 1'b0, '0});
    hdr_rows.push_back('{32'hFFEB_9000, 1'b0, '0});
    hdr_rows.push_back('{32'hFFF9_9000, 1'b0, '0});
    hdr_rows.push_back('{32'hFFFB_0000, 1'b0, '0});
    hdr_rows.push_back('{32'hFFFB_F000, 1'b0, '0});
    hdr_rows.push_back('{32'hFFFB_9C00, 1'b0, '0});
    hdr_rows.push_back('{32'hFEFB_9000, 1'b0, '0});
    hdr_rows.push_back('{32'hFFDB_9000, 1'b0, '0});
    hdr_rows.push_back('{32'h7FFB_9000, 1'b0, '0});
    hdr_rows.push_back('{32'hFFF3_1440, 1'b0, '0});
    hdr_rows.push_back('{32'hFFE3_E2C0, 1'b0, '0});
    hdr_rows.push_back('{32'hFFE7_E0C4, 1'b0, '0});
    hdr_rows.push_back('{32'hFFF7_E2F4, 1'b0, '0});
    hdr_rows.push_back('{32'hFFFC_1008, 1'b0, '0});
    hdr_rows.push_back('{32'hFFFA_E4B0, 1'b0, '0});
    hdr_rows.push_back('{32'hFFE2_1540, 1'b0, '0});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (hdr_rows[i])
      send_hdr(hdr_rows[i].word,
               hdr_rows[i].typed ? hdr_rows[i].want : decode_header(hdr_rows[i].word));

    // every valid version, layer, bitrate, sample rate and padding combination
    for (int v = mahd_pkg::VER_MPEG25; v <= mahd_pkg::VER_MPEG1; v++) begin
      if (v == mahd_pkg::VER_RSVD) continue;
      for (int l = mahd_pkg::LAY_III; l <= mahd_pkg::LAY_I; l++)
        for (int b = mahd_pkg::BRI_FREE + 1; b < mahd_pkg::BRI_BAD; b++)
          for (int s = mahd_pkg::SRI_11K; s < mahd_pkg::SRI_RSVD; s++)
            for (int p = 0; p < 2; p++) begin
              w = form_header(2'(v), 2'(l), 4'(b), 2'(s), 1'(p));
              send_hdr(w, decode_header(w));
            end
    end

    repeat (600) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        w = $urandom;
      end else begin
        w = form_header(($urandom_range(0, 2) == 0) ? mahd_pkg::VER_MPEG25 :
                        ($urandom_range(0, 1) == 0) ? mahd_pkg::VER_MPEG2 : mahd_pkg::VER_MPEG1,
                        2'($urandom_range(mahd_pkg::LAY_III, mahd_pkg::LAY_I)),
                        4'($urandom_range(mahd_pkg::BRI_FREE + 1, mahd_pkg::BRI_BAD - 1)),
                        2'($urandom_range(mahd_pkg::SRI_11K, mahd_pkg::SRI_RSVD - 1)),
                        1'($urandom_range(0, 1)));
        if (pick == 1) begin
          case ($urandom_range(0, 7))
            0: w[31:24] = w[31:24] ^ 8'(1 << $urandom_range(0, 7));
            1: w[23:21] = w[23:21] ^ 3'(1 << $urandom_range(0, 2));
            2: w[20:19] = mahd_pkg::VER_RSVD;
            3: w[18:17] = mahd_pkg::LAY_RSVD;
            4: w[15:12] = mahd_pkg::BRI_FREE;
            5: w[15:12] = mahd_pkg::BRI_BAD;
            6: w[11:10] = mahd_pkg::SRI_RSVD;
            default: w[1:0] = mahd_pkg::EMPH_RSVD;
          endcase
        end
      end
      send_hdr(w, decode_header(w));
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_hdrs.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
